FILE: rtl/bole_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package bole_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;

  localparam logic [3:0] CMD_INS_FIRST = 4'd0;
  localparam logic [3:0] CMD_INS_LAST  = 4'd1;
  localparam logic [3:0] CMD_SORTED    = 4'd2;
  localparam logic [3:0] CMD_DEL_FIRST = 4'd3;
  localparam logic [3:0] CMD_DEL_LAST  = 4'd4;
  localparam logic [3:0] CMD_DEL_VALUE = 4'd5;
  localparam logic [3:0] CMD_SEARCH    = 4'd6;
  localparam logic [3:0] CMD_ROTATE    = 4'd7;
  localparam logic [3:0] CMD_SIZE      = 4'd8;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic copy;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic go_scan;
    logic go_copy;
    logic scan_end;
    logic copy_end;
  } sts_t;

endpackage

FILE: rtl/bole_datapath.sv
// Element ring memory, scan and copy engines, and result register.
module bole_datapath (
  input  logic               clk,
  input  logic               rst,
  input  bole_pkg::ctl_t     ctl,
  output bole_pkg::sts_t     sts,
  input  logic [3:0]         in_cmd,
  input  logic signed [31:0] in_value,
  input  logic [5:0]         in_position,
  output logic [2:0]         out_status,
  output logic [5:0]         out_found_index,
  output logic [6:0]         out_element_count
);
  import bole_pkg::*;

  logic [31:0]        mem [DEPTH];
  logic [31:0]        rdata;
  logic [AW-1:0]      head;
  logic [CW-1:0]      count;
  logic [3:0]         cmd_r;
  logic signed [31:0] val_r;
  logic [5:0]         pos_r;
  logic [CW-1:0]      ridx, sidx, ins_at;
  logic               sv;
  logic [CW-1:0]      cp_src, cp_dst, cp_n, pend_dst;
  logic               cp_up, pend;
  logic [2:0]         status_r;
  logic [5:0]         fidx_r;

  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        wdata;
  logic               full, hit;
  logic [CW-1:0]      pos_w, ins_w;
  logic [2:0]         exec_status;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] x);
    return h + x[AW-1:0];
  endfunction

  assign full  = count >= CW'(DEPTH);
  assign pos_w = CW'(pos_r);

  always_comb begin
    if (cmd_r == CMD_SORTED) begin
      if (sidx == '0) hit = !($signed(val_r) > $signed(rdata));
      else            hit = $signed(rdata) > $signed(val_r);
    end else begin
      hit = rdata == val_r;
    end
  end

  assign ins_w = hit ? sidx : count;

  // Status decided at execute time; scans may still turn it into not found
  always_comb begin
    exec_status = ST_OK;
    case (cmd_r)
      CMD_INS_FIRST, CMD_INS_LAST, CMD_SORTED: if (full) exec_status = ST_FULL;
      CMD_DEL_FIRST, CMD_DEL_LAST: if (count == '0) exec_status = ST_EMPTY;
      CMD_DEL_VALUE, CMD_SEARCH: if (count == '0) exec_status = ST_NOTFOUND;
      CMD_ROTATE: if (pos_w >= count) exec_status = ST_RANGE;
      default: ;
    endcase
  end

  always_comb begin
    sts.scan_end = sv && (hit || sidx == count - CW'(1));
    sts.copy_end = (cp_n == '0) && !pend;
    sts.go_scan  = 1'b0;
    sts.go_copy  = 1'b0;
    if (ctl.exec) begin
      case (cmd_r)
        CMD_SORTED: sts.go_scan = !full && count != '0;
        CMD_DEL_VALUE, CMD_SEARCH: sts.go_scan = count != '0;
        CMD_ROTATE: sts.go_copy = pos_w < count && pos_w != '0;
        default: ;
      endcase
    end else if (ctl.scan) begin
      sts.go_copy = cmd_r == CMD_SORTED || (cmd_r == CMD_DEL_VALUE && hit);
    end
  end

  // Write port
  always_comb begin
    we    = 1'b0;
    waddr = head;
    wdata = val_r;
    if (ctl.exec && !full) begin
      case (cmd_r)
        CMD_INS_FIRST: begin
          we    = 1'b1;
          waddr = head - AW'(1);
        end
        CMD_INS_LAST: begin
          we    = 1'b1;
          waddr = phys(head, count);
        end
        CMD_SORTED: we = count == '0;
        default: ;
      endcase
    end else if (ctl.copy) begin
      if (pend) begin
        we    = 1'b1;
        waddr = phys(head, pend_dst);
        wdata = rdata;
      end else if (sts.copy_end && cmd_r == CMD_SORTED) begin
        we    = 1'b1;
        waddr = phys(head, ins_at);
      end
    end
  end

  // Read port
  always_comb begin
    re    = 1'b0;
    raddr = phys(head, ridx);
    if (ctl.scan && ridx < count) begin
      re = 1'b1;
    end else if (ctl.copy && cp_n != '0) begin
      re    = 1'b1;
      raddr = phys(head, cp_src);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      sv    <= 1'b0;
      pend  <= 1'b0;
      cp_n  <= '0;
    end else begin
      if (ctl.load) begin
        cmd_r <= in_cmd;
        val_r <= in_value;
        pos_r <= in_position;
      end
      if (ctl.exec) begin
        status_r <= exec_status;
        fidx_r   <= '0;
        ridx     <= '0;
        sv       <= 1'b0;
        pend     <= 1'b0;
        case (cmd_r)
          CMD_INS_FIRST, CMD_INS_LAST, CMD_SORTED: begin
            if (!full) begin
              if (cmd_r == CMD_INS_FIRST) begin
                head  <= head - AW'(1);
                count <= count + CW'(1);
              end else if (cmd_r == CMD_INS_LAST || count == '0) begin
                count <= count + CW'(1);
              end
            end
          end
          CMD_DEL_FIRST: begin
            if (count != '0) begin
              head  <= head + AW'(1);
              count <= count - CW'(1);
            end
          end
          CMD_DEL_LAST: begin
            if (count != '0) count <= count - CW'(1);
          end
          CMD_ROTATE: begin
            // move the leading entries past the tail, then advance head
            cp_src <= '0;
            cp_dst <= count;
            cp_n   <= pos_w;
            cp_up  <= 1'b1;
          end
          default: ;
        endcase
      end
      if (ctl.scan) begin
        if (re) begin
          ridx <= ridx + CW'(1);
          sidx <= ridx;
        end
        sv <= re;
        if (sts.scan_end) begin
          case (cmd_r)
            CMD_SORTED: begin
              ins_at <= ins_w;
              cp_src <= count - CW'(1);
              cp_dst <= count;
              cp_n   <= count - ins_w;
              cp_up  <= 1'b0;
            end
            CMD_DEL_VALUE: begin
              if (hit) begin
                cp_src <= sidx + CW'(1);
                cp_dst <= sidx;
                cp_n   <= count - CW'(1) - sidx;
                cp_up  <= 1'b1;
              end else begin
                status_r <= ST_NOTFOUND;
              end
            end
            default: begin
              if (hit) fidx_r <= 6'(sidx);
              else status_r <= ST_NOTFOUND;
            end
          endcase
        end
      end
      if (ctl.copy) begin
        if (cp_n != '0) begin
          cp_src   <= cp_up ? cp_src + CW'(1) : cp_src - CW'(1);
          cp_dst   <= cp_up ? cp_dst + CW'(1) : cp_dst - CW'(1);
          cp_n     <= cp_n - CW'(1);
          pend     <= 1'b1;
          pend_dst <= cp_dst;
        end else begin
          pend <= 1'b0;
        end
        if (sts.copy_end) begin
          case (cmd_r)
            CMD_SORTED:    count <= count + CW'(1);
            CMD_DEL_VALUE: count <= count - CW'(1);
            default:       head  <= head + AW'(pos_r);
          endcase
        end
      end
      if (ctl.emit) begin
        out_status        <= status_r;
        out_found_index   <= fidx_r;
        out_element_count <= 7'(count);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("element count above capacity");
  assert property (@(posedge clk) disable iff (rst)
    (ctl.copy && sts.copy_end && cmd_r == CMD_SORTED) |-> count < CW'(DEPTH))
    else $error("sorted insert commits into a full list");
  assert property (@(posedge clk) disable iff (rst) (ctl.scan && sv) |-> sidx < count)
    else $error("scan compares an entry beyond the tail");

endmodule

FILE: rtl/bole_controller.sv
// Command sequencer: accept, execute, scan, copy and result hand-off.
module bole_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output bole_pkg::ctl_t ctl,
  input  bole_pkg::sts_t sts
);
  import bole_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_COPY = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state, state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    ctl.load = state == S_IDLE && in_valid;
    ctl.exec = state == S_EXEC;
    ctl.scan = state == S_SCAN;
    ctl.copy = state == S_COPY;
    ctl.emit = state == S_DONE && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        if (sts.go_scan)      state_next = S_SCAN;
        else if (sts.go_copy) state_next = S_COPY;
        else                  state_next = S_DONE;
      end
      S_SCAN: if (sts.scan_end) state_next = sts.go_copy ? S_COPY : S_DONE;
      S_COPY: if (sts.copy_end) state_next = S_DONE;
      S_DONE: if (ctl.emit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.emit)      out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) ctl.emit |=> out_valid)
    else $error("result not presented after hand-off");
  assert property (@(posedge clk) disable iff (rst) (state == S_DONE && !ctl.emit) |=> state == S_DONE)
    else $error("result dropped while output stalled");
  assert property (@(posedge clk) disable iff (rst) ctl.load |=> state == S_EXEC)
    else $error("accepted item not executed");

endmodule

FILE: rtl/bounded_ordered_list_engine.sv
// List engine top: controller plus a datapath holding one 64-entry element memory.
// One item in flight: the next item is taken only after the last result is handed off.
// End inserts/deletes, size, refused and unknown commands need no scan or copy; a search
// scans to the match or the tail; delete by value also moves later entries down on a match;
// sorted insert scans a non-empty list, then shifts entries up from the insert point;
// rotate copies leading entries past the tail. Reset empties the list, no sweep.
module bounded_ordered_list_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // cmd[3:0], value[35:4], position[41:36], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status[2:0], found_index[8:3], element_count[15:9]
);
  import bole_pkg::*;

  ctl_t       ctl;
  sts_t       sts;
  logic [2:0] status;
  logic [5:0] found_index;
  logic [6:0] element_count;

  bole_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .ctl       (ctl),
    .sts       (sts)
  );

  bole_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .sts               (sts),
    .in_cmd            (s_tdata[3:0]),
    .in_value          ($signed(s_tdata[35:4])),
    .in_position       (s_tdata[41:36]),
    .out_status        (status),
    .out_found_index   (found_index),
    .out_element_count (element_count)
  );

  assign m_tdata = {element_count, found_index, status};

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the bounded ordered list engine: random command stream with a scoreboard.
module tb_top;
  import bole_pkg::*;

  typedef struct packed {
    logic [5:0]  position;
    logic [31:0] value;
    logic [3:0]  cmd;
  } cmd_item_t;

  typedef struct packed {
    logic [6:0] element_count;
    logic [5:0] found_index;
    logic [2:0] status;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  bounded_ordered_list_engine uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cmd_item_t   pending_cmds[$];
  reply_t      expected_replies[$];
  logic [31:0] list_mirror[$];
  int          errors = 0;
  bit          quiet_tail = 0;
  bit          stim_done = 0;
  int          idle_cycles = 0;

  // Apply one command to the mirror list and return the reply it should give.
  function automatic reply_t list_apply(cmd_item_t c);
    reply_t r;
    int n;
    int i;
    logic [31:0] tmp[$];
    r = '0;
    n = list_mirror.size();
    case (c.cmd)
      CMD_INS_FIRST, CMD_INS_LAST, CMD_SORTED: begin
        if (n >= DEPTH) r.status = ST_FULL;
        else if (c.cmd == CMD_INS_FIRST) list_mirror.push_front(c.value);
        else if (c.cmd == CMD_INS_LAST) list_mirror.insert(n, c.value);
        else if (n == 0 || $signed(c.value) <= $signed(list_mirror[0]))
          list_mirror.push_front(c.value);
        else begin
          i = 1;
          while (i < n && !($signed(list_mirror[i]) > $signed(c.value))) i++;
          list_mirror.insert(i, c.value);
        end
      end
      CMD_DEL_FIRST: if (n == 0) r.status = ST_EMPTY; else void'(list_mirror.pop_front());
      CMD_DEL_LAST:  if (n == 0) r.status = ST_EMPTY; else void'(list_mirror.pop_back());
      CMD_DEL_VALUE, CMD_SEARCH: begin
        i = 0;
        while (i < n && list_mirror[i] != c.value) i++;
        if (i == n) r.status = ST_NOTFOUND;
        else if (c.cmd == CMD_DEL_VALUE) list_mirror.delete(i);
        else r.found_index = i[5:0];
      end
      CMD_ROTATE: begin
        if (c.position >= n) r.status = ST_RANGE;
        else if (c.position != 0) begin
          for (i = 0; i < n; i++) tmp.insert(i, list_mirror[(i + c.position) % n]);
          list_mirror = tmp;
        end
      end
      default: ;
    endcase
    r.element_count = 7'(list_mirror.size());
    return r;
  endfunction

  // Random values mostly come from a small pool so that searches and deletes hit.
  function automatic cmd_item_t rand_cmd(int mode);
    cmd_item_t c;
    int sel;
    c.cmd = 4'($urandom_range(0, 8));
    if (mode == 1) c.cmd = 4'($urandom_range(0, 2));
    if (mode == 2) c.cmd = 4'($urandom_range(3, 8));
    if ($urandom_range(0, 29) == 0) c.cmd = 4'($urandom_range(9, 15));
    sel = $urandom_range(0, 9);
    if (sel < 6) c.value = $urandom_range(0, 15) - 8;
    else if (sel == 6) c.value = 32'h8000_0000 | $urandom_range(0, 3);
    else if (sel == 7) c.value = 32'h7fff_fffc | $urandom_range(0, 3);
    else c.value = $urandom;
    c.position = ($urandom_range(0, 1)) ? 6'($urandom_range(0, 8)) : 6'($urandom);
    return c;
  endfunction

  function automatic cmd_item_t mk(logic [3:0] op, logic [31:0] v, int p);
    cmd_item_t c;
    c.cmd = op; c.value = v; c.position = 6'(p);
    return c;
  endfunction

  // Append one item to the stimulus queue.
  function automatic void queue_cmd(cmd_item_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  initial begin
    int k;
    int mode;
    // directed: empty-list corners, extremes, every op, unknown op
    queue_cmd(mk(CMD_DEL_FIRST, 0, 0));
    queue_cmd(mk(CMD_DEL_LAST, 0, 0));
    queue_cmd(mk(CMD_DEL_VALUE, 5, 0));
    queue_cmd(mk(CMD_SEARCH, 5, 0));
    queue_cmd(mk(CMD_ROTATE, 0, 0));
    queue_cmd(mk(CMD_SORTED, 32'h0000_0005, 0));
    queue_cmd(mk(CMD_SORTED, 32'h8000_0000, 0));
    queue_cmd(mk(CMD_SORTED, 32'h7fff_ffff, 0));
    queue_cmd(mk(CMD_SORTED, 32'hffff_ffff, 0));
    queue_cmd(mk(CMD_INS_FIRST, 32'hffff_ffff, 0));
    queue_cmd(mk(CMD_INS_LAST, 32'h0000_0000, 63));
    queue_cmd(mk(CMD_SEARCH, 32'h7fff_ffff, 0));
    queue_cmd(mk(CMD_SEARCH, 32'h1234_5678, 0));
    queue_cmd(mk(CMD_ROTATE, 0, 3));
    queue_cmd(mk(CMD_ROTATE, 0, 0));
    queue_cmd(mk(CMD_ROTATE, 0, 6));
    queue_cmd(mk(CMD_ROTATE, 0, 63));
    queue_cmd(mk(CMD_DEL_VALUE, 32'hffff_ffff, 0));
    queue_cmd(mk(CMD_DEL_VALUE, 32'h1234_5678, 0));
    queue_cmd(mk(CMD_SIZE, 32'hffff_ffff, 63));
    queue_cmd(mk(4'hf, 32'h5555_aaaa, 42));
    queue_cmd(mk(4'h9, 0, 0));
    queue_cmd(mk(CMD_DEL_FIRST, 0, 0));
    queue_cmd(mk(CMD_DEL_LAST, 0, 0));
    // random: phases that fill to full, drain to empty, and mix
    for (k = 0; k < 1830; k++) begin
      if (k % 300 < 90) mode = 1;
      else if (k % 300 < 200) mode = 0;
      else mode = 2;
      queue_cmd(rand_cmd(mode));
    end
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 1'b0;
  end

  // Handshake seen at the rising edge, consumed by the driver at the next falling edge.
  logic s_tready_q = 1'b0;
  always @(posedge clk) s_tready_q <= s_tready;

  // Driver: offer items at the falling edge with random gaps.
  int drv_gap = 0;
  cmd_item_t cur;
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready_q) begin
        expected_replies.insert(expected_replies.size(), list_apply(cur));
        if (pending_cmds.size() < 60) quiet_tail = 1;
      end
      if (!(s_tvalid && !s_tready_q)) begin
        if (drv_gap > 0) begin
          drv_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0 && !quiet_tail && $urandom_range(0, 5) == 0) begin
          drv_gap = $urandom_range(0, 6);
          s_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur = pending_cmds.pop_front();
          s_tdata <= {6'b0, cur};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
          stim_done = 1;
        end
      end
    end
  end

  // Receiver: random stall bursts plus one long hold-off.
  int rcv_gap = 0;
  int hold_cnt = 0;
  bit hold_done = 0;
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (!hold_done && expected_replies.size() > 0 && pending_cmds.size() < 1200) begin
      hold_cnt++;
      m_tready <= 1'b0;
      if (hold_cnt >= 300) hold_done = 1;
    end else if (rcv_gap > 0) begin
      rcv_gap--;
      m_tready <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      rcv_gap = $urandom_range(0, 6);
      m_tready <= 1'b0;
    end else m_tready <= 1'b1;
  end

  // Monitor and watchdog.
  reply_t got;
  reply_t want;
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected reply %h", $time, m_tdata);
          errors++;
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status)
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          if (got.found_index !== want.found_index)
            $display("%0t: found_index expected %0d actual %0d", $time,
                     want.found_index, got.found_index);
          if (got.element_count !== want.element_count)
            $display("%0t: element_count expected %0d actual %0d", $time,
                     want.element_count, got.element_count);
          if (got !== want) errors++;
        end
      end
    end
  end

  initial begin
    wait (stim_done && expected_replies.size() == 0 && !s_tvalid);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_replies.size() == 0)
      $display("bounded_ordered_list_engine: match");
    else
      $display("bounded_ordered_list_engine: mismatch");
    $finish;
  end

  initial begin
    wait (idle_cycles >= 2000);
    $display("bounded_ordered_list_engine: mismatch");
    $finish;
  end
endmodule

FILE: sim.f
rtl/bole_pkg.sv
rtl/bole_datapath.sv
rtl/bole_controller.sv
rtl/bounded_ordered_list_engine.sv
bench/tb_top.sv
